[src/cirf_pkg.sv]
// Types, stage map and helpers for the contact impulse and friction resolver.
package cirf_pkg;

  typedef struct packed {
    logic [47:0] vel_a;
    logic [47:0] vel_b;
    logic [47:0] contact_normal;
    logic [47:0] point_a;
    logic [47:0] point_b;
    logic [15:0] mass_a;
    logic [15:0] mass_b;
    logic [23:0] material_a;
    logic [23:0] material_b;
    logic        kinematic_a;
    logic        kinematic_b;
  } in_t;

  typedef struct packed {
    logic [47:0] pos_shift_a;
    logic [47:0] pos_shift_b;
    logic [47:0] new_vel_a;
    logic [47:0] new_vel_b;
    logic        approaching;
  } out_t;

  // Everything one contact carries down the pipeline.
  typedef struct packed {
    logic [2:0][15:0] va;
    logic [2:0][15:0] vb;
    logic [2:0][15:0] n;
    logic [2:0][15:0] sha;
    logic [2:0][15:0] shb;
    logic [15:0]      ma;
    logic [15:0]      mb;
    logic [16:0]      msum;
    logic             ka;
    logic             kb;
    logic [15:0]      e;
    logic [8:0]       mud;
    logic [16:0]      ssq;
    logic [2:0][32:0] dprod;
    logic             appr;
    logic [33:0]      negnv;
    logic [33:0]      pp_hi;
    logic [33:0]      pp_lo;
    logic [35:0]      d1_dq;
    logic [16:0]      d1_rem;
    logic [35:0]      mu_x;
    logic [18:0]      mu_rem;
    logic [17:0]      mu_root;
    logic [35:0]      jq;
    logic [16:0]      mu;
    logic [2:0][52:0] jn;
    logic [2:0][55:0] pa;
    logic [2:0][55:0] pb;
    logic [2:0][15:0] wa;
    logic [2:0][15:0] wb;
    logic [2:0][16:0] rv;
    logic [2:0][32:0] rvn;
    logic [34:0]      nv2;
    logic [2:0][50:0] nn;
    logic [2:0][27:0] t;
    logic [2:0][53:0] tsq;
    logic [55:0]      sq_x;
    logic [28:0]      sq_rem;
    logic [27:0]      sq_root;
    logic [2:0]       tneg;
    logic [2:0][15:0] ud_dq;
    logic [2:0][27:0] ud_rem;
    logic [2:0][15:0] u;
    logic [2:0][32:0] rvu;
    logic             fneg;
    logic [35:0]      d3_dq;
    logic [16:0]      d3_rem;
    logic [35:0]      fab;
    logic [36:0]      fs;
    logic [52:0]      jmu;
    logic [2:0][52:0] ju;
    logic [2:0][52:0] fu;
    logic             stat;
    logic [2:0][38:0] fus;
    logic [2:0][48:0] dyn;
    logic [2:0][40:0] fr;
    logic [2:0][57:0] qa;
    logic [2:0][57:0] qb;
    out_t             res;
  } ctx_t;

  localparam int DIV_STEPS = 4;
  localparam int MU_STEPS  = 2;
  localparam int SQ_STEPS  = 4;
  localparam int UD_STEPS  = 4;

  localparam int ST_IN   = 0;
  localparam int ST_NVP  = 1;
  localparam int ST_NVS  = 2;
  localparam int ST_NUM  = 3;
  localparam int ST_QIN  = 4;
  localparam int ST_D1   = 5;
  localparam int D1_STG  = 36 / DIV_STEPS;
  localparam int ST_IMP1 = ST_D1 + D1_STG;
  localparam int ST_IMP2 = ST_IMP1 + 1;
  localparam int ST_IMP3 = ST_IMP2 + 1;
  localparam int ST_F1   = ST_IMP3 + 1;
  localparam int ST_F2   = ST_F1 + 1;
  localparam int ST_F3   = ST_F2 + 1;
  localparam int ST_F4   = ST_F3 + 1;
  localparam int ST_F5   = ST_F4 + 1;
  localparam int ST_F6   = ST_F5 + 1;
  localparam int ST_SQ   = ST_F6 + 1;
  localparam int SQ_STG  = 28 / SQ_STEPS;
  localparam int ST_UD   = ST_SQ + SQ_STG;
  localparam int UD_STG  = 16 / UD_STEPS;
  localparam int ST_U    = ST_UD + UD_STG;
  localparam int ST_RVU  = ST_U + 1;
  localparam int ST_FV   = ST_RVU + 1;
  localparam int ST_D3   = ST_FV + 1;
  localparam int D3_STG  = 36 / DIV_STEPS;
  localparam int ST_FQ   = ST_D3 + D3_STG;
  localparam int ST_MUL  = ST_FQ + 1;
  localparam int ST_SHF  = ST_MUL + 1;
  localparam int ST_FR   = ST_SHF + 1;
  localparam int ST_FRM  = ST_FR + 1;
  localparam int ST_FIN  = ST_FRM + 1;
  localparam int NSTG    = ST_FIN + 1;

  function automatic logic [15:0] sat16(input logic signed [43:0] x);
    if (x > 44'sd32767) return 16'h7fff;
    else if (x < -44'sd32768) return 16'h8000;
    else return x[15:0];
  endfunction

endpackage

[src/contact_impulse_friction_resolver.sv]
// Contact impulse and friction resolver: one contact in, one result word out.
//
// Input channel in_valid/in_ready/in_data carries one contact word: both
// velocities, the normal, both contact points, masses, materials and kinematic
// flags. Output channel out_valid/out_ready/out_data carries the position
// shifts, the new velocities and the approaching flag.
// The datapath is a 52-stage pipeline. One word is accepted per cycle while
// the output is not stalled. Most of the depth sits in four iterative units
// laid out as stages: the impulse, friction and tangent dividers (4 quotient
// bits per stage) and the tangent length square root (4 root bits per stage).
// When out_valid is high and out_ready is low the whole pipeline holds; the
// first stage still takes one more word if it is empty, and no word is lost
// or repeated. Synchronous reset (rst_n low) empties every stage; the payload
// registers are not cleared.
module contact_impulse_friction_resolver (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cirf_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cirf_pkg::out_t  out_data
);
  import cirf_pkg::*;

  ctx_t            pipe_r   [NSTG];
  ctx_t            pipe_nxt [NSTG];
  logic [NSTG-1:0] vld_r;
  logic            ce;
  logic            en0;

  assign ce        = ~vld_r[NSTG-1] | out_ready;
  assign en0       = ce | ~vld_r[0];
  assign in_ready  = en0;
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = pipe_r[NSTG-1].res;

  // Entry: unpack, position shifts, material products.
  always_comb begin : c_in
    ctx_t o;
    logic [15:0] pa, pb;
    logic [15:0] sqa, sqb;
    logic signed [16:0] dab, dba;
    o = '0;
    o.va   = in_data.vel_a;
    o.vb   = in_data.vel_b;
    o.n    = in_data.contact_normal;
    o.ma   = in_data.mass_a;
    o.mb   = in_data.mass_b;
    o.ka   = in_data.kinematic_a;
    o.kb   = in_data.kinematic_b;
    o.msum = {1'b0, in_data.mass_a} + {1'b0, in_data.mass_b};
    o.e    = in_data.material_a[7:0] * in_data.material_b[7:0];
    o.mud  = {1'b0, in_data.material_a[23:16]} + {1'b0, in_data.material_b[23:16]};
    sqa    = in_data.material_a[15:8] * in_data.material_a[15:8];
    sqb    = in_data.material_b[15:8] * in_data.material_b[15:8];
    o.ssq  = {1'b0, sqa} + {1'b0, sqb};
    for (int i = 0; i < 3; i++) begin
      pa = in_data.point_a[16*i +: 16];
      pb = in_data.point_b[16*i +: 16];
      dab = $signed({pa[15], pa}) - $signed({pb[15], pb});
      dba = $signed({pb[15], pb}) - $signed({pa[15], pa});
      o.sha[i] = in_data.kinematic_a ? 16'h0000 : sat16({{27{dab[16]}}, dab});
      o.shb[i] = in_data.kinematic_b ? 16'h0000 : sat16({{27{dba[16]}}, dba});
    end
    pipe_nxt[ST_IN] = o;
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_stg
    if (k == ST_NVP) begin : g_nvp
      always_comb begin
        ctx_t c, o;
        logic signed [16:0] dv;
        logic signed [32:0] p;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          dv = $signed({c.vb[i][15], c.vb[i]}) - $signed({c.va[i][15], c.va[i]});
          p  = dv * $signed(c.n[i]);
          o.dprod[i] = p;
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_NVS) begin : g_nvs
      always_comb begin
        ctx_t c, o;
        logic signed [34:0] nv, nneg;
        c = pipe_r[k-1];
        o = c;
        nv = $signed(c.dprod[0]) + $signed(c.dprod[1]) + $signed(c.dprod[2]);
        nneg = -nv;
        o.appr  = nv[34];
        o.negnv = nneg[33:0];
        pipe_nxt[k] = o;
      end
    end else if (k == ST_NUM) begin : g_num
      always_comb begin
        ctx_t c, o;
        logic [16:0] ee;
        c = pipe_r[k-1];
        o = c;
        ee = {1'b0, c.e} + 17'h10000;
        // split the 34-bit speed so each product stays 17 x 17
        o.pp_hi = ee * c.negnv[33:17];
        o.pp_lo = ee * c.negnv[16:0];
        pipe_nxt[k] = o;
      end
    end else if (k == ST_QIN) begin : g_qin
      always_comb begin
        ctx_t c, o;
        logic [50:0] num;
        c = pipe_r[k-1];
        o = c;
        num = {c.pp_hi, 17'b0} + {17'b0, c.pp_lo};
        o.d1_dq   = num[49:14];
        o.d1_rem  = '0;
        o.mu_x    = {3'b0, c.ssq, 16'b0};
        o.mu_rem  = '0;
        o.mu_root = '0;
        pipe_nxt[k] = o;
      end
    end else if (k >= ST_D1 && k < ST_IMP1) begin : g_d1
      always_comb begin
        ctx_t c, o;
        logic [17:0] rs;
        logic [20:0] r2;
        logic [19:0] tr;
        c = pipe_r[k-1];
        o = c;
        // impulse divider: J = (num >> 14) / msum
        for (int s = 0; s < DIV_STEPS; s++) begin
          rs = {o.d1_rem, o.d1_dq[35]};
          o.d1_dq = {o.d1_dq[34:0], 1'b0};
          if (rs >= {1'b0, o.msum}) begin
            rs = rs - {1'b0, o.msum};
            o.d1_dq[0] = 1'b1;
          end
          o.d1_rem = rs[16:0];
        end
        // static friction coefficient root runs alongside
        for (int s = 0; s < MU_STEPS; s++) begin
          r2 = {o.mu_rem, o.mu_x[35:34]};
          o.mu_x = {o.mu_x[33:0], 2'b00};
          tr = {o.mu_root, 2'b01};
          if (r2 >= {1'b0, tr}) begin
            r2 = r2 - {1'b0, tr};
            o.mu_root = {o.mu_root[16:0], 1'b1};
          end else begin
            o.mu_root = {o.mu_root[16:0], 1'b0};
          end
          o.mu_rem = r2[18:0];
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_IMP1) begin : g_imp1
      always_comb begin
        ctx_t c, o;
        logic [35:0] jv;
        logic signed [52:0] p;
        c = pipe_r[k-1];
        o = c;
        jv = (c.msum == 17'd0) ? 36'd0 : c.d1_dq;
        o.jq = jv;
        o.mu = c.mu_root[16:0];
        for (int i = 0; i < 3; i++) begin
          p = $signed({1'b0, jv}) * $signed(c.n[i]);
          o.jn[i] = p;
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_IMP2) begin : g_imp2
      always_comb begin
        ctx_t c, o;
        logic signed [52:0] js;
        logic signed [55:0] qa, qb;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          js = $signed(c.jn[i]) >>> 14;
          qa = $signed(js[38:0]) * $signed({1'b0, c.ma});
          qb = $signed(js[38:0]) * $signed({1'b0, c.mb});
          o.pa[i] = qa;
          o.pb[i] = qb;
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_IMP3) begin : g_imp3
      always_comb begin
        ctx_t c, o;
        logic signed [55:0] sa, sb;
        logic signed [43:0] xa, xb;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          sa = $signed(c.pa[i]) >>> 16;
          sb = $signed(c.pb[i]) >>> 16;
          xa = $signed({{28{c.va[i][15]}}, c.va[i]}) - $signed(sa[43:0]);
          xb = $signed({{28{c.vb[i][15]}}, c.vb[i]}) + $signed(sb[43:0]);
          o.wa[i] = c.ka ? c.va[i] : sat16(xa);
          o.wb[i] = c.kb ? c.vb[i] : sat16(xb);
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_F1) begin : g_f1
      always_comb begin
        ctx_t c, o;
        logic signed [16:0] dv;
        logic signed [32:0] p;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          dv = $signed({c.wb[i][15], c.wb[i]}) - $signed({c.wa[i][15], c.wa[i]});
          p  = dv * $signed(c.n[i]);
          o.rv[i]  = dv;
          o.rvn[i] = p;
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_F2) begin : g_f2
      always_comb begin
        ctx_t c, o;
        logic signed [34:0] s;
        c = pipe_r[k-1];
        o = c;
        s = $signed(c.rvn[0]) + $signed(c.rvn[1]) + $signed(c.rvn[2]);
        o.nv2 = s;
        pipe_nxt[k] = o;
      end
    end else if (k == ST_F3) begin : g_f3
      always_comb begin
        ctx_t c, o;
        logic signed [50:0] p;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          p = $signed(c.nv2) * $signed(c.n[i]);
          o.nn[i] = p;
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_F4) begin : g_f4
      always_comb begin
        ctx_t c, o;
        logic signed [50:0] sh;
        logic signed [29:0] tt;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          sh = $signed(c.nn[i]) >>> 22;
          tt = $signed({c.rv[i], 6'b0}) - $signed(sh[29:0]);
          o.t[i] = tt[27:0];
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_F5) begin : g_f5
      always_comb begin
        ctx_t c, o;
        logic signed [55:0] sq;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          sq = $signed(c.t[i]) * $signed(c.t[i]);
          o.tsq[i] = sq[53:0];
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_F6) begin : g_f6
      always_comb begin
        ctx_t c, o;
        logic [27:0] tm;
        logic signed [27:0] tn;
        c = pipe_r[k-1];
        o = c;
        o.sq_x = {2'b00, c.tsq[0]} + {2'b00, c.tsq[1]} + {2'b00, c.tsq[2]};
        o.sq_rem  = '0;
        o.sq_root = '0;
        // tangent divider starts on |t| << 14, quotient fits 16 bits
        for (int i = 0; i < 3; i++) begin
          tn = -$signed(c.t[i]);
          tm = c.t[i][27] ? tn : c.t[i];
          o.tneg[i]   = c.t[i][27];
          o.ud_rem[i] = {3'b000, tm[26:2]};
          o.ud_dq[i]  = {tm[1:0], 14'b0};
        end
        pipe_nxt[k] = o;
      end
    end else if (k >= ST_SQ && k < ST_UD) begin : g_sq
      always_comb begin
        ctx_t c, o;
        logic [30:0] r2;
        logic [29:0] tr;
        c = pipe_r[k-1];
        o = c;
        for (int s = 0; s < SQ_STEPS; s++) begin
          r2 = {o.sq_rem, o.sq_x[55:54]};
          o.sq_x = {o.sq_x[53:0], 2'b00};
          tr = {o.sq_root, 2'b01};
          if (r2 >= {1'b0, tr}) begin
            r2 = r2 - {1'b0, tr};
            o.sq_root = {o.sq_root[26:0], 1'b1};
          end else begin
            o.sq_root = {o.sq_root[26:0], 1'b0};
          end
          o.sq_rem = r2[28:0];
        end
        pipe_nxt[k] = o;
      end
    end else if (k >= ST_UD && k < ST_U) begin : g_ud
      always_comb begin
        ctx_t c, o;
        logic [28:0] rs;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          for (int s = 0; s < UD_STEPS; s++) begin
            rs = {o.ud_rem[i], o.ud_dq[i][15]};
            o.ud_dq[i] = {o.ud_dq[i][14:0], 1'b0};
            if (rs >= {1'b0, c.sq_root}) begin
              rs = rs - {1'b0, c.sq_root};
              o.ud_dq[i][0] = 1'b1;
            end
            o.ud_rem[i] = rs[27:0];
          end
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_U) begin : g_u
      always_comb begin
        ctx_t c, o;
        logic [15:0] qn;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          qn = -c.ud_dq[i];
          // zero-length tangent: no direction, no friction
          if (c.sq_root == 28'd0) o.u[i] = '0;
          else o.u[i] = c.tneg[i] ? qn : c.ud_dq[i];
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_RVU) begin : g_rvu
      always_comb begin
        ctx_t c, o;
        logic signed [32:0] p;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          p = $signed(c.rv[i]) * $signed(c.u[i]);
          o.rvu[i] = p;
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_FV) begin : g_fv
      always_comb begin
        ctx_t c, o;
        logic signed [34:0] fv, fvn;
        logic [34:0] fm;
        c = pipe_r[k-1];
        o = c;
        fv  = $signed(c.rvu[0]) + $signed(c.rvu[1]) + $signed(c.rvu[2]);
        fvn = -fv;
        fm  = fv[34] ? fvn : fv;
        o.fneg   = ~fv[34] & (fv != 35'sd0);
        o.d3_dq  = {fm[33:0], 2'b00};
        o.d3_rem = '0;
        pipe_nxt[k] = o;
      end
    end else if (k >= ST_D3 && k < ST_FQ) begin : g_d3
      always_comb begin
        ctx_t c, o;
        logic [17:0] rs;
        c = pipe_r[k-1];
        o = c;
        for (int s = 0; s < DIV_STEPS; s++) begin
          rs = {o.d3_rem, o.d3_dq[35]};
          o.d3_dq = {o.d3_dq[34:0], 1'b0};
          if (rs >= {1'b0, o.msum}) begin
            rs = rs - {1'b0, o.msum};
            o.d3_dq[0] = 1'b1;
          end
          o.d3_rem = rs[16:0];
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_FQ) begin : g_fq
      always_comb begin
        ctx_t c, o;
        logic [35:0] af;
        logic [36:0] afn;
        c = pipe_r[k-1];
        o = c;
        af  = (c.msum == 17'd0) ? 36'd0 : c.d3_dq;
        afn = -{1'b0, af};
        o.fab = af;
        o.fs  = c.fneg ? afn : {1'b0, af};
        pipe_nxt[k] = o;
      end
    end else if (k == ST_MUL) begin : g_mul
      always_comb begin
        ctx_t c, o;
        logic signed [52:0] pj, pf;
        c = pipe_r[k-1];
        o = c;
        o.jmu = c.jq * c.mu;
        for (int i = 0; i < 3; i++) begin
          pj = $signed({1'b0, c.jq}) * $signed(c.u[i]);
          pf = $signed(c.fs) * $signed(c.u[i]);
          o.ju[i] = pj;
          o.fu[i] = pf;
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_SHF) begin : g_shf
      always_comb begin
        ctx_t c, o;
        logic signed [52:0] f1, j1;
        logic signed [48:0] dy;
        c = pipe_r[k-1];
        o = c;
        o.stat = ({1'b0, c.fab, 16'b0} < c.jmu);
        for (int i = 0; i < 3; i++) begin
          f1 = $signed(c.fu[i]) >>> 14;
          j1 = $signed(c.ju[i]) >>> 14;
          dy = $signed(j1[38:0]) * $signed({1'b0, c.mud});
          o.fus[i] = f1[38:0];
          o.dyn[i] = dy;
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_FR) begin : g_fr
      always_comb begin
        ctx_t c, o;
        logic signed [48:0] d1;
        logic signed [40:0] f;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          d1 = $signed(c.dyn[i]) >>> 9;
          // static when |F| stays under the cone, else scaled dynamic
          f  = c.stat ? $signed(c.fus[i]) : -$signed(d1[39:0]);
          o.fr[i] = f;
        end
        pipe_nxt[k] = o;
      end
    end else if (k == ST_FRM) begin : g_frm
      always_comb begin
        ctx_t c, o;
        logic signed [57:0] qa, qb;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          qa = $signed(c.fr[i]) * $signed({1'b0, c.ma});
          qb = $signed(c.fr[i]) * $signed({1'b0, c.mb});
          o.qa[i] = qa;
          o.qb[i] = qb;
        end
        pipe_nxt[k] = o;
      end
    end else begin : g_fin
      always_comb begin
        ctx_t c, o;
        logic signed [57:0] sa, sb;
        logic signed [43:0] xa, xb;
        logic [2:0][15:0] fa, fb;
        c = pipe_r[k-1];
        o = c;
        for (int i = 0; i < 3; i++) begin
          sa = $signed(c.qa[i]) >>> 16;
          sb = $signed(c.qb[i]) >>> 16;
          xa = $signed({{28{c.wa[i][15]}}, c.wa[i]}) - $signed(sa[43:0]);
          xb = $signed({{28{c.wb[i][15]}}, c.wb[i]}) + $signed(sb[43:0]);
          fa[i] = c.ka ? c.wa[i] : sat16(xa);
          fb[i] = c.kb ? c.wb[i] : sat16(xb);
        end
        o.res.pos_shift_a = c.sha;
        o.res.pos_shift_b = c.shb;
        // separating contacts pass the input velocities through
        o.res.new_vel_a   = c.appr ? fa : c.va;
        o.res.new_vel_b   = c.appr ? fb : c.vb;
        o.res.approaching = c.appr;
        pipe_nxt[k] = o;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0) pipe_r[0] <= pipe_nxt[0];
    for (int k = 1; k < NSTG; k++) begin
      if (ce) pipe_r[k] <= pipe_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en0) vld_r[0] <= in_valid;
      if (ce) vld_r[NSTG-1:1] <= vld_r[NSTG-2:0];
    end
  end

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (vld_r[NSTG-1] && !out_ready && vld_r[0]))
    else $error("input blocked without an output stall");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result word changed while stalled");

  a_kinematic_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && pipe_r[NSTG-1].ka) |-> (out_data.pos_shift_a == 48'd0))
    else $error("kinematic body A got a position shift");

endmodule

[sim/tb_contact_impulse_friction_resolver.sv]
// Testbench for the contact impulse and friction resolver: directed and random contacts.
module tb_contact_impulse_friction_resolver;
  import cirf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  out_t expected_results[$];

  contact_impulse_friction_resolver dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic longint comp(input logic [47:0] v, input int k);
    return longint'($signed(v[16*k +: 16]));
  endfunction

  function automatic longint clip16(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic logic [47:0] pack_vec(input longint c[3]);
    logic [47:0] r;
    for (int k = 0; k < 3; k++) r[16*k +: 16] = 16'(clip16(c[k]));
    return r;
  endfunction

  function automatic longint floor_shr(input longint x, input int s);
    return x >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_t resolve_contact(input in_t c);
    out_t o;
    longint va[3], vb[3], n[3], sa[3], sb[3], rv[3], t[3], u[3], fr[3];
    longint ma, mb, msum, nv, nv2, fv, j, f, e, num, absf, mu, mud, imp;
    longint s1, s2;
    longint unsigned len2, len;
    ma = c.mass_a; mb = c.mass_b; msum = ma + mb;
    nv = 0; nv2 = 0; fv = 0; j = 0; f = 0; len2 = 0;
    for (int i = 0; i < 3; i++) begin
      va[i] = comp(c.vel_a, i);
      vb[i] = comp(c.vel_b, i);
      n[i] = comp(c.contact_normal, i);
      sa[i] = c.kinematic_a ? 0 : comp(c.point_a, i) - comp(c.point_b, i);
      sb[i] = c.kinematic_b ? 0 : comp(c.point_b, i) - comp(c.point_a, i);
      nv += (vb[i] - va[i]) * n[i];
    end
    o.pos_shift_a = pack_vec(sa);
    o.pos_shift_b = pack_vec(sb);
    if (nv >= 0) begin
      o.new_vel_a = pack_vec(va);
      o.new_vel_b = pack_vec(vb);
      o.approaching = 1'b0;
      return o;
    end
    e = longint'(c.material_a[7:0]) * longint'(c.material_b[7:0]);
    num = (65536 + e) * (-nv);
    if (msum != 0) j = num / (msum << 14);
    for (int i = 0; i < 3; i++) begin
      imp = floor_shr(j * n[i], 14);
      if (!c.kinematic_a) va[i] = clip16(va[i] - floor_shr(imp * ma, 16));
      if (!c.kinematic_b) vb[i] = clip16(vb[i] + floor_shr(imp * mb, 16));
    end
    for (int i = 0; i < 3; i++) begin
      rv[i] = vb[i] - va[i];
      nv2 += rv[i] * n[i];
    end
    for (int i = 0; i < 3; i++) begin
      t[i] = rv[i] * 64 - floor_shr(nv2 * n[i], 22);
      len2 += longint'(t[i] * t[i]);
    end
    len = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      u[i] = (len != 0) ? (t[i] * 16384) / longint'(len) : 0;
      fv += rv[i] * u[i];
    end
    s1 = c.material_a[15:8];
    s2 = c.material_b[15:8];
    mu = longint'(int_sqrt((s1 * s1 + s2 * s2) << 16));
    mud = longint'(c.material_a[23:16]) + longint'(c.material_b[23:16]);
    if (msum != 0) f = (-fv * 4) / msum;
    absf = f < 0 ? -f : f;
    for (int i = 0; i < 3; i++) begin
      if (absf * 65536 < j * mu) fr[i] = floor_shr(f * u[i], 14);
      else fr[i] = -floor_shr(floor_shr(j * u[i], 14) * mud, 9);
      if (!c.kinematic_a) va[i] = clip16(va[i] - floor_shr(fr[i] * ma, 16));
      if (!c.kinematic_b) vb[i] = clip16(vb[i] + floor_shr(fr[i] * mb, 16));
    end
    o.new_vel_a = pack_vec(va);
    o.new_vel_b = pack_vec(vb);
    o.approaching = 1'b1;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // Drive one contact word and wait until the block takes it; valid stays up
  // afterwards so the next word can follow without a gap.
  task automatic send_contact(input in_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    expected_results.push_back(resolve_contact(c));
    in_data <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", out_data.new_vel_a, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.pos_shift_a !== want.pos_shift_a)
          report_mismatch("pos_shift_a", out_data.pos_shift_a, want.pos_shift_a);
        if (out_data.pos_shift_b !== want.pos_shift_b)
          report_mismatch("pos_shift_b", out_data.pos_shift_b, want.pos_shift_b);
        if (out_data.new_vel_a !== want.new_vel_a)
          report_mismatch("new_vel_a", out_data.new_vel_a, want.new_vel_a);
        if (out_data.new_vel_b !== want.new_vel_b)
          report_mismatch("new_vel_b", out_data.new_vel_b, want.new_vel_b);
        if (out_data.approaching !== want.approaching)
          report_mismatch("approaching", 48'(out_data.approaching), 48'(want.approaching));
      end
    end
  end

  function automatic logic [47:0] rand_vec(input int span);
    logic [47:0] r;
    for (int k = 0; k < 3; k++)
      r[16*k +: 16] = 16'($signed($urandom_range(2 * span)) - span);
    return r;
  endfunction

  function automatic logic [47:0] rand_normal();
    logic [47:0] r;
    int axis;
    r = '0;
    axis = $urandom_range(2);
    r[16*axis +: 16] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    // tilt a little off the axis
    r[16*((axis + 1) % 3) +: 16] = 16'($signed($urandom_range(4000)) - 2000);
    return r;
  endfunction

  function automatic in_t rand_contact(input bit shaped);
    in_t c;
    logic [351:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(in_t)-1:0];
    if (c.mass_a == 0) c.mass_a = 1;
    if (c.mass_b == 0) c.mass_b = 1;
    if (shaped) begin
      c.vel_a = rand_vec($urandom_range(1) ? 2000 : 32767);
      c.vel_b = rand_vec(2000);
      c.contact_normal = rand_normal();
      c.mass_a = $urandom_range(1) ? 16'($urandom_range(64, 1024))
                                   : 16'($urandom_range(1, 65535));
      c.mass_b = 16'($urandom_range(64, 2048));
      c.kinematic_a = ($urandom_range(7) == 0);
      c.kinematic_b = ($urandom_range(7) == 0);
    end
    return c;
  endfunction

  task automatic test_directed();
    in_t c;
    c = '0;
    c.mass_a = 16'h0100; c.mass_b = 16'h0100;
    c.contact_normal = {16'sd0, 16'sd0, 16'sd16384};
    c.vel_a = {16'sd0, 16'sd256, 16'sd512};
    c.material_a = 24'h40_80_ff; c.material_b = 24'h40_80_ff;
    send_contact(c);                         // approaching, with friction
    c.vel_a = {16'sd0, 16'sd0, 16'sd512};
    send_contact(c);                         // zero tangent
    c.vel_a = {16'sd0, 16'sd0, -16'sd512};
    send_contact(c);                         // separating
    c.vel_a = '0;
    send_contact(c);                         // resting
    c.vel_a = {16'sd0, 16'sd100, 16'sd512};
    c.kinematic_a = 1'b1; send_contact(c);
    c.kinematic_b = 1'b1; send_contact(c);
    c.kinematic_a = 1'b0; send_contact(c);
    c.kinematic_b = 1'b0;
    c.point_a = {3{16'h7fff}}; c.point_b = {3{16'h8000}};
    send_contact(c);                         // shifts saturate
    c.vel_a = {3{16'h7fff}}; c.vel_b = {3{16'h8000}};
    c.mass_a = 16'hffff; c.mass_b = 16'hffff;
    c.contact_normal = {3{16'sd16384}};       // non-unit normal
    send_contact(c);
    c.mass_a = 16'h0001; c.mass_b = 16'h0001;
    c.material_a = '1; c.material_b = '1;
    send_contact(c);
    c.contact_normal = {3{16'h8000}};
    c.vel_a = {3{16'h8000}}; c.vel_b = {3{16'h7fff}};
    send_contact(c);
    c.material_a = '0; c.material_b = '0;
    send_contact(c);
    c.material_a = 24'hff_00_00; c.material_b = 24'h00_ff_ff;
    c.vel_a = {16'sd0, 16'sd300, 16'sd300}; c.vel_b = '0;
    c.contact_normal = {16'sd0, 16'sd0, 16'sd16384};
    c.mass_a = 16'h0200; c.mass_b = 16'h0080;
    send_contact(c);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_contact(rand_contact($urandom_range(99) < 85));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    send_idle_pct = 23; recv_idle_pct = 72;
    test_random(450);
    send_idle_pct = 72; recv_idle_pct = 23;
    test_random(450);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(450);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
